FILE: rtl/core/lom_pkg.sv
// Shared types, constants and sequencer states of the limit order matcher.
package lom_pkg;

	localparam int DEF_BOOK_ENTRIES = 32;
	localparam int FEE_DIV          = 100;
	localparam int DIV_STEPS        = 10;   // 40-bit dividend, one nibble a step

	// result kinds
	localparam logic [1:0] KIND_FILL   = 2'd0;
	localparam logic [1:0] KIND_RESTED = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// order side
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic        op;
		logic [19:0] order_id;
		logic [7:0]  client_id;
		logic [19:0] quantity;
		logic [19:0] limit_price;
	} order_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] resting_order_id;
		logic [7:0]  resting_client_id;
		logic [19:0] fill_qty;
		logic [39:0] fill_value;
		logic [33:0] fill_fee;
		logic [19:0] remaining_qty;
		logic [47:0] fees_collected;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_DVS,
		S_DVW,
		S_EMIT,
		S_REMOVE,
		S_FINAL,
		S_IPOS,
		S_INS
	} state_t;

endpackage

FILE: rtl/core/lom_order_if.sv
// Request channel carrying incoming orders.
interface lom_order_if import lom_pkg::*; ();
	logic   valid;
	logic   ready;
	order_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lom_result_if.sv
// Result channel carrying fills and final order status.
interface lom_result_if import lom_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lom_div100.sv
// Iterative divide by one hundred, one dividend nibble per cycle.
module lom_div100 import lom_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int SW = $clog2(DIV_STEPS + 1);

	logic [SW-1:0] step_q;
	logic [39:0]   x_q;
	logic [33:0]   q_q;
	logic [6:0]    r_q;
	logic          done_q;

	logic [10:0] t;
	logic [3:0]  d;
	logic [10:0] sub;

	// one long-division digit: partial remainder times 16 plus next nibble
	always_comb begin
		t = {r_q, x_q[39:36]};
		d = 4'd0;
		for (int j = 1; j < 16; j++) begin
			if (t >= 11'(j * FEE_DIV))
				d = 4'(j);
		end
		sub = 11'(d) * 11'(FEE_DIV);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= SW'(DIV_STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1))
					done_q <= 1'b1;
			end
		end
	end

	// datapath; quotient of a 40-bit dividend by 100 fits 34 bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.dividend;
			r_q <= '0;
			q_q <= '0;
		end else if (step_q != '0) begin
			x_q <= {x_q[35:0], 4'd0};
			r_q <= 7'(t - sub);
			q_q <= {q_q[29:0], d};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = q_q;

endmodule

FILE: rtl/core/limit_order_matcher.sv
// Limit order matcher: one order accepted at a time, fills walked by a scan sequencer.
// Steps per order: accept; per fill a scan of the book, a multiply, a divide-by-100 for
// the fee, an emit and, when the resting order empties, a removal; then, unless the order
// is filled, a last scan, and a final step. A rested remainder adds a position scan
// and an insert.
// Throughput: one order at a time, ready only when the sequencer is idle; reset clears
// the sequencer, entry count and fee total, book contents undefined.
module limit_order_matcher import lom_pkg::*; #(
	parameter int BOOK_ENTRIES = DEF_BOOK_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	lom_order_if.sink     order,
	lom_result_if.source  result
);

	localparam int IW = $clog2(BOOK_ENTRIES);
	localparam int CW = $clog2(BOOK_ENTRIES + 1);

	// book store
	logic [20:0] sp_q  [BOOK_ENTRIES];
	logic [19:0] qty_q [BOOK_ENTRIES];
	logic [27:0] own_q [BOOK_ENTRIES];
	logic [CW-1:0] cnt_q;

	// current order
	logic        op_q;
	logic [19:0] oid_q;
	logic [7:0]  tid_q;
	logic [19:0] rem_q;
	logic [19:0] px_q;

	// scan and fill
	state_t        state_q, state_d;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [19:0]   bestp_q;
	logic          found_q;
	logic [19:0]   f_q;
	logic [39:0]   val_q;
	logic [33:0]   fee_q;
	logic [47:0]   fee_tot_q;

	// output register
	logic    res_vld_q;
	result_t res_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        slot_free;
	logic        load;
	result_t     res_d;
	logic        cand;
	logic [20:0] e_sp;
	logic        e_side;
	logic [19:0] e_px;
	logic [19:0] q_left;

	lom_div100 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign slot_free = !res_vld_q || result.ready;
	assign order.ready = (state_q == S_IDLE);
	assign result.valid = res_vld_q;
	assign result.data  = res_q;

	assign div_req.start    = (state_q == S_DVS);
	assign div_req.dividend = val_q + 40'd50;

	// entry under the scan pointer
	assign e_sp   = sp_q[idx_q[IW-1:0]];
	assign e_side = e_sp[20];
	assign e_px   = e_sp[19:0];
	assign q_left = qty_q[best_q] - f_q;

	// crossing test against the best so far
	always_comb begin
		cand = 1'b0;
		if (e_side != op_q) begin
			if (op_q == SIDE_BUY)
				cand = (e_px <= px_q) && (!found_q || e_px < bestp_q);
			else
				cand = (e_px >= px_q) && (!found_q || e_px > bestp_q);
		end
	end

	// next state and result
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		res_d   = '0;
		res_d.fees_collected = fee_tot_q;
		case (state_q)
			S_IDLE: begin
				if (order.valid)
					state_d = S_FINAL;
				if (order.valid && order.data.quantity != '0)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (idx_q == cnt_q)
					state_d = found_q ? S_MUL : S_FINAL;
			end
			S_MUL: state_d = S_DVS;
			S_DVS: state_d = S_DVW;
			S_DVW: begin
				if (div_rsp.done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				res_d.kind              = KIND_FILL;
				res_d.resting_order_id  = own_q[best_q][19:0];
				res_d.resting_client_id = own_q[best_q][27:20];
				res_d.fill_qty          = f_q;
				res_d.fill_value        = val_q;
				res_d.fill_fee          = fee_q;
				res_d.remaining_qty     = rem_q - f_q;
				res_d.fees_collected    = fee_tot_q + {14'd0, fee_q};
				if (slot_free) begin
					load = 1'b1;
					if (q_left == '0)
						state_d = S_REMOVE;
					else if (rem_q != f_q)
						state_d = S_SCAN;
					else
						state_d = S_FINAL;
				end
			end
			S_REMOVE: state_d = (rem_q != '0) ? S_SCAN : S_FINAL;
			S_FINAL: begin
				res_d.last          = 1'b1;
				res_d.remaining_qty = rem_q;
				if (rem_q == '0) begin
					res_d.kind = KIND_DONE;
					if (slot_free) begin
						load    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (cnt_q < CW'(BOOK_ENTRIES)) begin
					state_d = S_IPOS;
				end else begin
					res_d.kind = KIND_REJECT;
					if (slot_free) begin
						load    = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_IPOS: begin
				if (idx_q == cnt_q || e_px < px_q)
					state_d = S_INS;
			end
			S_INS: begin
				res_d.kind          = KIND_RESTED;
				res_d.last          = 1'b1;
				res_d.remaining_qty = rem_q;
				if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			fee_tot_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (load)
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
			if (state_q == S_EMIT && load)
				fee_tot_q <= fee_tot_q + {14'd0, fee_q};
			if (state_q == S_REMOVE)
				cnt_q <= cnt_q - 1'b1;
			if (state_q == S_INS && load)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// order, scan and fill datapath
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
		case (state_q)
			S_IDLE: begin
				op_q    <= order.data.op;
				oid_q   <= order.data.order_id;
				tid_q   <= order.data.client_id;
				rem_q   <= order.data.quantity;
				px_q    <= order.data.limit_price;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			S_SCAN: begin
				if (idx_q != cnt_q) begin
					if (cand) begin
						found_q <= 1'b1;
						best_q  <= idx_q[IW-1:0];
						bestp_q <= e_px;
					end
					idx_q <= idx_q + 1'b1;
				end else begin
					f_q <= (rem_q < qty_q[best_q]) ? rem_q : qty_q[best_q];
				end
			end
			S_MUL: val_q <= 40'(bestp_q) * 40'(f_q);
			S_DVW: begin
				if (div_rsp.done)
					fee_q <= div_rsp.quotient;
			end
			S_EMIT: begin
				if (load) begin
					rem_q   <= rem_q - f_q;
					idx_q   <= '0;
					found_q <= 1'b0;
				end
			end
			S_FINAL: idx_q <= '0;
			S_IPOS: begin
				if (!(idx_q == cnt_q || e_px < px_q))
					idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// book store updates: fill decrement, close-up removal, shifted insertion
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && load)
			qty_q[best_q] <= q_left;
		if (state_q == S_REMOVE) begin
			for (int i = 0; i < BOOK_ENTRIES - 1; i++) begin
				if (CW'(i) >= CW'(best_q) && CW'(i + 1) < cnt_q) begin
					sp_q[i]  <= sp_q[i + 1];
					qty_q[i] <= qty_q[i + 1];
					own_q[i] <= own_q[i + 1];
				end
			end
		end
		if (state_q == S_INS && load) begin
			for (int i = 1; i < BOOK_ENTRIES; i++) begin
				if (CW'(i) > idx_q && CW'(i) <= cnt_q) begin
					sp_q[i]  <= sp_q[i - 1];
					qty_q[i] <= qty_q[i - 1];
					own_q[i] <= own_q[i - 1];
				end
			end
			sp_q[idx_q[IW-1:0]]  <= {op_q, px_q};
			qty_q[idx_q[IW-1:0]] <= rem_q;
			own_q[idx_q[IW-1:0]] <= {tid_q, oid_q};
		end
	end

endmodule
